// File: design/csp_pkg.sv
// Shared widths and carried-record types for the swept circle predictor.
// No dependencies.
package csp_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int DW    = 33;   // coordinate differences
  localparam int PW    = 66;   // 33x33 products
  localparam int SW    = 67;   // cross and dot
  localparam int VVW   = 66;   // |v|^2
  localparam int RRW   = 64;   // R^2
  localparam int CMW   = 66;   // |cross|
  localparam int WW    = 132;  // cc and R^2*vv
  localparam int DSQW  = 130;  // radicand
  localparam int ROOTW = 65;   // floor sqrt
  localparam int SQRW  = 68;   // sqrt partial remainder
  localparam int NUMW  = 69;   // -dot - root, signed
  localparam int MAGW  = 68;   // |num|
  localparam int QB    = 33;   // quotient bits kept before saturation
  localparam int XW    = 128;  // divider datapath
  localparam int TW    = 32;   // contact_time

  typedef struct packed {
    logic                  vzero;
    logic                  hit0;
    logic                  miss;
    logic signed [SW-1:0]  dot;
    logic [VVW-1:0]        vv;
  } side_t;

  typedef struct packed {
    logic vzero;
    logic hit0;
    logic miss;
    logic dle0;
    logic neg;
    logic ovf;
  } flags_t;

endpackage

// File: design/csp_front.sv
// Front stages: differences, products, cross/dot, squared terms, radicand.
// Depends on csp_pkg.
module csp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [31:0]           first_pos_x,
  input  logic signed [31:0]           first_pos_y,
  input  logic signed [31:0]           first_vel_x,
  input  logic signed [31:0]           first_vel_y,
  input  logic [30:0]                  first_radius,
  input  logic signed [31:0]           second_pos_x,
  input  logic signed [31:0]           second_pos_y,
  input  logic signed [31:0]           second_vel_x,
  input  logic signed [31:0]           second_vel_y,
  input  logic [30:0]                  second_radius,
  output logic                         out_valid,
  output logic [csp_pkg::DSQW-1:0]     radicand,
  output csp_pkg::side_t               side
);
  import csp_pkg::*;

  logic [6:0] vld;

  // stage 1
  logic signed [DW-1:0] dx, dy, vx, vy;
  logic [31:0] reach;
  // stage 2
  logic signed [PW-1:0] pvx, pvy, pcx, pcy, pdx, pdy, pdd_x, pdd_y;
  logic [RRW-1:0] rr2;
  // stage 3
  logic [VVW-1:0] vv3, dd3;
  logic signed [SW-1:0] cross3, dot3;
  logic [RRW-1:0] rr3;
  // stage 4
  logic [CMW-1:0] cmag;
  logic [VVW-1:0] vv4;
  logic [RRW-1:0] rr4;
  logic signed [SW-1:0] dot4;
  logic vzero4, hit04;
  // stage 5
  logic [65:0] ch_ch, ch_cl, cl_cl;
  logic [65:0] rh_vh;
  logic [63:0] rh_vl;
  logic [65:0] rl_vh;
  logic [63:0] rl_vl;
  side_t s5;
  // stage 6
  logic [WW-1:0] cc6, rv6;
  side_t s6;
  logic [WW-1:0] diff6;
  side_t side_next;

  assign diff6 = rv6 - cc6;

  // miss verdict joins the carried record on its way out
  always_comb begin
    side_next      = s6;
    side_next.miss = cc6 > rv6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx    <= DW'(second_pos_x) - DW'(first_pos_x);
      dy    <= DW'(second_pos_y) - DW'(first_pos_y);
      vx    <= DW'(second_vel_x) - DW'(first_vel_x);
      vy    <= DW'(second_vel_y) - DW'(first_vel_y);
      reach <= 32'(first_radius) + 32'(second_radius);

      pvx   <= vx * vx;
      pvy   <= vy * vy;
      pcx   <= vx * dy;
      pcy   <= vy * dx;
      pdx   <= vx * dx;
      pdy   <= vy * dy;
      pdd_x <= dx * dx;
      pdd_y <= dy * dy;
      rr2   <= RRW'(reach) * RRW'(reach);

      vv3    <= $unsigned(pvx) + $unsigned(pvy);
      dd3    <= $unsigned(pdd_x) + $unsigned(pdd_y);
      cross3 <= SW'(pcx) - SW'(pcy);
      dot3   <= SW'(pdx) + SW'(pdy);
      rr3    <= rr2;

      cmag   <= cross3[SW-1] ? CMW'(-cross3) : CMW'(cross3);
      vv4    <= vv3;
      rr4    <= rr3;
      dot4   <= dot3;
      vzero4 <= (vv3 == '0);
      hit04  <= ({2'b0, rr3} >= dd3);

      // split the square of |cross| and the product R^2*|v|^2 into partial products
      ch_ch    <= cmag[65:33] * cmag[65:33];
      ch_cl    <= cmag[65:33] * cmag[32:0];
      cl_cl    <= cmag[32:0] * cmag[32:0];
      rh_vh    <= 66'(rr4[63:32]) * 66'(vv4[65:32]);
      rh_vl    <= 64'(rr4[63:32]) * 64'(vv4[31:0]);
      rl_vh    <= 66'(rr4[31:0]) * 66'(vv4[65:32]);
      rl_vl    <= 64'(rr4[31:0]) * 64'(vv4[31:0]);
      s5.vzero <= vzero4;
      s5.hit0  <= hit04;
      s5.miss  <= 1'b0;
      s5.dot   <= dot4;
      s5.vv    <= vv4;

      cc6 <= (WW'(ch_ch) << 66) + (WW'(ch_cl) << 34) + WW'(cl_cl);
      rv6 <= (WW'(rh_vh) << 64) + (WW'(rh_vl) << 32) + (WW'(rl_vh) << 32) + WW'(rl_vl);
      s6  <= s5;

      radicand  <= diff6[DSQW-1:0];
      side      <= side_next;
    end
  end

  assign out_valid = vld[6];

endmodule

// File: design/csp_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage.
// Depends on csp_pkg.
module csp_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [csp_pkg::DSQW-1:0]   radicand,
  input  csp_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [csp_pkg::ROOTW-1:0]  root,
  output csp_pkg::side_t             out_side
);
  import csp_pkg::*;

  localparam int N = ROOTW;

  logic              vld  [0:N];
  logic [SQRW-1:0]   rem  [0:N];
  logic [ROOTW-1:0]  rt   [0:N];
  logic [DSQW-1:0]   opnd [0:N];
  side_t             sd   [0:N];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign opnd[0] = radicand;
  assign sd[0]   = in_side;

  for (genvar g = 1; g <= N; g++) begin : g_stage
    logic [SQRW-1:0] r2, trial;
    logic            ge;
    assign r2    = {rem[g-1][SQRW-3:0], opnd[g-1][DSQW-1 -: 2]};
    assign trial = {1'b0, rt[g-1], 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= ge ? r2 - trial : r2;
        rt[g]   <= {rt[g-1][ROOTW-2:0], ge};
        opnd[g] <= opnd[g-1] << 2;
        sd[g]   <= sd[g-1];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = rt[N];
  assign out_side  = sd[N];

endmodule

// File: design/csp_div.sv
// Numerator, pipelined restoring divide by |v|^2, saturation and verdict.
// Depends on csp_pkg.
module csp_div #(
  parameter int FRACTION_BITS = csp_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [csp_pkg::ROOTW-1:0]  root,
  input  csp_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic                       collides,
  output logic signed [csp_pkg::TW-1:0] contact_time
);
  import csp_pkg::*;

  // N1: signed numerator
  logic                   v1;
  logic signed [NUMW-1:0] num1;
  flags_t                 f1;
  logic [VVW-1:0]         vv1;
  // N2: magnitude
  logic                   v2;
  logic [MAGW-1:0]        mag2;
  flags_t                 f2;
  flags_t                 f2_next;
  logic [VVW-1:0]         vv2;

  always_comb begin
    f2_next     = f1;
    f2_next.neg = num1[NUMW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1     <= -NUMW'(in_side.dot) - $signed({4'b0, root});
      f1.vzero <= in_side.vzero;
      f1.hit0  <= in_side.hit0;
      f1.miss  <= in_side.miss;
      f1.dle0  <= in_side.dot[SW-1] || (in_side.dot == '0);
      f1.neg   <= 1'b0;
      f1.ovf   <= 1'b0;
      vv1      <= in_side.vv;

      mag2     <= num1[NUMW-1] ? MAGW'(-num1) : MAGW'(num1);
      f2       <= f2_next;
      vv2      <= vv1;
    end
  end

  // divider stages; index 0 is the scaled numerator with overflow check
  logic           vld [0:QB];
  logic [XW-1:0]  rem [0:QB];
  logic [QB-1:0]  q   [0:QB];
  logic [VVW-1:0] vv  [0:QB];
  flags_t         fl  [0:QB];
  logic [XW-1:0]  scaled;
  flags_t         fl0_next;

  assign scaled = XW'(mag2) << FRACTION_BITS;

  always_comb begin
    fl0_next     = f2;
    fl0_next.ovf = scaled >= (XW'(vv2) << QB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= scaled;
      q[0]      <= '0;
      vv[0]     <= vv2;
      fl[0]     <= fl0_next;
    end
  end

  for (genvar g = 1; g <= QB; g++) begin : g_stage
    logic [XW-1:0] dsh;
    logic          ge;
    assign dsh = XW'(vv[g-1]) << (QB - g);
    assign ge  = rem[g-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g] <= ge ? rem[g-1] - dsh : rem[g-1];
        q[g]   <= {q[g-1][QB-2:0], ge};
        vv[g]  <= vv[g-1];
        fl[g]  <= fl[g-1];
      end
    end
  end

  // saturation and verdict
  flags_t         ff;
  logic [QB-1:0]  qf;
  logic           big;
  logic [TW-1:0]  sat;
  logic           vout;

  assign ff  = fl[QB];
  assign qf  = q[QB];
  assign big = ff.ovf || qf[QB-1] || qf[TW-1];

  always_comb begin
    if (ff.neg) begin
      sat = big ? {1'b1, {(TW-1){1'b0}}} : TW'(-qf[TW-1:0]);
    end else begin
      sat = big ? {1'b0, {(TW-1){1'b1}}} : qf[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      collides     <= ff.vzero ? ff.hit0 : (!ff.miss && ff.dle0);
      contact_time <= (ff.vzero || ff.miss) ? '0 : $signed(sat);
    end
  end

  assign out_valid = vout;

endmodule

// File: design/swept_circle_collision_predictor_core.sv
// Top level of the swept circle contact predictor: front stages, square root
// pipeline, divider pipeline and output register with skid. Uses csp_pkg.
//
//   channel  | handshake                   | payload
//   pair     | pair_valid / pair_stall     | first_*, second_* (position, velocity, radius)
//   result   | result_valid / result_stall | collides, contact_time
//
// One pair is taken every cycle while pair_stall is low; a result passes through
// 7 front stages, 65 root stages, 3 + 33 divider stages, a verdict stage and the
// output register. The root and divider pipelines make up most of that depth.
// Reset (rst, synchronous) empties every stage; payload registers keep junk.
// A stalled result parks one finished item in the skid register; only then
// does pair_stall rise and the whole pipeline hold.
module swept_circle_collision_predictor_core #(
  parameter int FRACTION_BITS = csp_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_valid,
  output logic               pair_stall,
  input  logic signed [31:0] first_pos_x,
  input  logic signed [31:0] first_pos_y,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic [30:0]        first_radius,
  input  logic signed [31:0] second_pos_x,
  input  logic signed [31:0] second_pos_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic [30:0]        second_radius,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               collides,
  output logic signed [31:0] contact_time
);
  import csp_pkg::*;

  logic                en;
  logic                fr_valid, sq_valid, dv_valid;
  logic [DSQW-1:0]     radicand;
  side_t               fr_side, sq_side;
  logic [ROOTW-1:0]    root;
  logic                dv_collides;
  logic signed [TW-1:0] dv_time;

  // skid register
  logic                skid_full;
  logic                skid_collides;
  logic signed [TW-1:0] skid_time;

  // whole pipeline advances unless the skid holds an item
  assign en         = !skid_full;
  assign pair_stall = skid_full;

  csp_front u_front (
    .clk, .rst, .en,
    .in_valid (pair_valid),
    .first_pos_x, .first_pos_y, .first_vel_x, .first_vel_y, .first_radius,
    .second_pos_x, .second_pos_y, .second_vel_x, .second_vel_y, .second_radius,
    .out_valid (fr_valid),
    .radicand  (radicand),
    .side      (fr_side)
  );

  csp_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (fr_valid),
    .radicand  (radicand),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (root),
    .out_side  (sq_side)
  );

  csp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk, .rst, .en,
    .in_valid     (sq_valid),
    .root         (root),
    .in_side      (sq_side),
    .out_valid    (dv_valid),
    .collides     (dv_collides),
    .contact_time (dv_time)
  );

  logic incoming, out_take;
  assign incoming = en && dv_valid;
  assign out_take = result_valid && !result_stall;

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end
    end else if (!result_valid || out_take) begin
      result_valid <= incoming;
    end else if (incoming) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_take) begin
        collides     <= skid_collides;
        contact_time <= skid_time;
      end
    end else if (!result_valid || out_take) begin
      collides     <= dv_collides;
      contact_time <= dv_time;
    end else begin
      skid_collides <= dv_collides;
      skid_time     <= dv_time;
    end
  end

  // skid only ever holds an item behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result_valid)
    else $error("skid full without a pending result");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(result_valid && result_stall && dv_valid))
    else $error("skid filled without a stalled transfer");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_full && result_stall |=> skid_full && result_valid)
    else $error("skid item dropped during stall");

endmodule
